// ----- rtl/cftm_pkg.sv -----
// Shared types and constants for the cyclic frame tick monitor.
// No dependencies; imported by cyclic_frame_tick_monitor_unit.
package cftm_pkg;

    // Event kinds carried in the input tuser field.
    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_WAIT   = 2'd1;
    localparam logic [1:0] MODE_RESYNC = 2'd2;

    // Field widths.
    localparam int unsigned TsW      = 32;
    localparam int unsigned CntW     = 32;
    localparam int unsigned WideW    = 64;
    localparam int unsigned SlotW    = 10;
    localparam int unsigned CfgW     = 11;
    localparam int unsigned SumW     = CntW + 1;
    localparam int unsigned DivCntW  = 6;
    localparam int unsigned OutBits  = 3 + SlotW + 2 * WideW + 6 * CntW;
    localparam int unsigned OutBytes = (OutBits + 7) / 8;
    localparam int unsigned OutW     = OutBytes * 8;

    // Slot count limits.
    localparam logic [CfgW-1:0] SlotsMax   = 11'd1024;
    localparam logic [CfgW-1:0] SlotsReset = 11'd10;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PEND = 5'b00010,
        S_UPD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

endpackage

// ----- rtl/cyclic_frame_tick_monitor_unit.sv -----
// Cyclic frame tick monitor: top level with sequencer and shared remainder unit.
// Depends on cftm_pkg.
//
// Usage:
//   The slave stream takes one event per transaction: s_axis_tuser holds the
//   event kind (minor tick, loop-end wait, resync) and s_axis_tdata the 32-bit
//   cycle-counter timestamp. Every event yields exactly one status transaction
//   on the master stream, a snapshot of the slot index, the flags and all
//   counters after the event.
//   The slot count register, written through i_cfg_wr_en / i_cfg_wr_data, resets
//   to 10 slots; the user must write it only while the block is idle (not enforced).
// Sequencing:
//   An event that advances no slot passes through the pend, update and emit states
//   into the output register, and the input is ready again once the sequencer is
//   back in idle. An event that advances the slot also runs the divide state: the
//   new slot is the remainder of a 33-bit sum by the slot count, found one bit per
//   cycle by a single shared compare-and-subtract unit. s_axis_tready is high only
//   while the sequencer is idle, so one event is in work at a time.
// Reset and stall:
//   The synchronous active-low reset clears all counters, flags and the
//   output valid. A status transaction waits in the output register while the
//   receiver stalls; the next event is still accepted, and its status waits
//   in the sequencer until the output register is free.
module cyclic_frame_tick_monitor_unit
    import cftm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgW-1:0]     i_cfg_wr_data,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // timestamp[31:0]
    input  logic [TsW-1:0]      s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // collected[0], waiting[1], major_due[2], slot_index[12:3],
    // elapsed_minor[76:13], major_count[140:77], overrun_count[172:141],
    // overrun_lost[204:173], overrun_peak[236:205], body_last[268:237],
    // body_worst[300:269], raw_ticks[332:301], zero fill[335:333]
    output logic [OutW-1:0]     m_axis_tdata
);

    // Sequencer and latched event.
    t_state              r_state;
    logic [1:0]          r_mode;
    logic [TsW-1:0]      r_ts;
    logic                r_done;

    // Architectural state.
    logic [CfgW-1:0]     r_slots_cfg;
    logic [CntW-1:0]     r_tick;
    logic [CntW-1:0]     r_consumed;
    logic [SlotW-1:0]    r_slot;
    logic [WideW-1:0]    r_elapsed;
    logic [WideW-1:0]    r_major;
    logic                r_due;
    logic [TsW-1:0]      r_body_start;
    logic                r_started;
    logic [CntW-1:0]     r_body_last;
    logic [CntW-1:0]     r_body_worst;
    logic [CntW-1:0]     r_ovr_events;
    logic [CntW-1:0]     r_ovr_lost;
    logic [CntW-1:0]     r_ovr_worst;
    logic                r_wait;

    // Values prepared one step ahead of the update.
    logic [CntW-1:0]     r_pend;
    logic [CntW-1:0]     r_lost;
    logic [CntW-1:0]     r_body;

    // Remainder unit.
    logic [SumW-1:0]     r_dvd;
    logic [CfgW-1:0]     r_rem;
    logic [DivCntW-1:0]  r_div_cnt;
    logic [CfgW-1:0]     r_div_n;

    // Output register.
    logic                r_out_valid;
    logic [OutW-1:0]     r_out_data;

    // Effective slot count, clamped into 1..1024.
    logic [CfgW-1:0]     eff_n;
    always_comb begin
        if (r_slots_cfg == '0) begin
            eff_n = CfgW'(1);
        end else if (r_slots_cfg > SlotsMax) begin
            eff_n = SlotsMax;
        end else begin
            eff_n = r_slots_cfg;
        end
    end

    // Decisions taken in the update step.
    logic                pend_nz;
    logic                pend_gt1;
    logic                is_tick;
    logic                is_wait;
    logic                is_resync;
    logic                do_collect;
    logic                do_step;
    logic                do_body;
    logic                do_major;
    logic [CfgW-1:0]     slot_inc;
    logic                slot_wrap;
    logic [CfgW-1:0]     slot_base;
    logic [SumW-1:0]     step_sum;
    logic                crossed;

    always_comb begin
        is_tick    = (r_mode == MODE_TICK);
        is_wait    = (r_mode == MODE_WAIT);
        is_resync  = (r_mode == MODE_RESYNC);
        pend_nz    = (r_pend != '0);
        pend_gt1   = pend_nz && (r_pend != CntW'(1));
        do_collect = (is_tick && r_wait) || (is_wait && !r_wait && pend_nz);
        do_step    = (do_collect || is_resync) && pend_nz;
        do_body    = is_wait && !r_wait && r_started;
        slot_inc   = {1'b0, r_slot} + CfgW'(1);
        slot_wrap  = (slot_inc >= eff_n);
        slot_base  = slot_wrap ? '0 : slot_inc;
        step_sum   = SumW'(slot_base) + SumW'(r_lost);
        crossed    = slot_wrap || (step_sum >= SumW'(eff_n));
        do_major   = do_step && do_collect && crossed;
    end

    // One restoring step of the remainder unit.
    logic [CfgW:0]       div_trial;
    logic [CfgW:0]       div_diff;
    logic                div_ge;
    always_comb begin
        div_trial = {r_rem, r_dvd[SumW-1]};
        div_ge    = (div_trial >= {1'b0, r_div_n});
        div_diff  = div_trial - {1'b0, r_div_n};
    end

    logic in_fire;
    logic out_free;
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_cfg <= SlotsReset;
        end else if (i_cfg_wr_en) begin
            r_slots_cfg <= i_cfg_wr_data;
        end
    end

    // Sequencer and state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mode       <= MODE_TICK;
            r_done       <= 1'b0;
            r_tick       <= '0;
            r_consumed   <= '0;
            r_slot       <= '0;
            r_elapsed    <= '0;
            r_major      <= '0;
            r_due        <= 1'b0;
            r_body_start <= '0;
            r_started    <= 1'b0;
            r_body_last  <= '0;
            r_body_worst <= '0;
            r_ovr_events <= '0;
            r_ovr_lost   <= '0;
            r_ovr_worst  <= '0;
            r_wait       <= 1'b0;
            r_div_cnt    <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_mode  <= s_axis_tuser;
                        r_ts    <= s_axis_tdata;
                        r_state <= S_PEND;
                        if (s_axis_tuser == MODE_TICK) begin
                            r_tick <= r_tick + CntW'(1);
                        end
                    end
                end
                S_PEND: begin
                    // Pending ticks, ticks beyond one, and the body time.
                    r_pend  <= r_tick - r_consumed;
                    r_lost  <= r_tick + ~r_consumed;
                    r_body  <= r_ts - r_body_start;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_done <= do_collect;
                    if (do_body) begin
                        r_body_last <= r_body;
                        if (r_body > r_body_worst) begin
                            r_body_worst <= r_body;
                        end
                    end
                    if (((is_wait && !r_wait) || is_resync) && !do_major) begin
                        r_due <= 1'b0;
                    end
                    if (is_wait && !r_wait && !pend_nz) begin
                        r_wait <= 1'b1;
                    end
                    if (do_collect || is_resync) begin
                        r_consumed   <= r_tick;
                        r_body_start <= r_ts;
                        r_started    <= 1'b1;
                        r_wait       <= 1'b0;
                    end
                    if (do_collect && pend_gt1) begin
                        r_ovr_events <= r_ovr_events + CntW'(1);
                        r_ovr_lost   <= r_ovr_lost + r_lost;
                        if (r_lost > r_ovr_worst) begin
                            r_ovr_worst <= r_lost;
                        end
                    end
                    if (do_step) begin
                        r_elapsed <= r_elapsed + WideW'(r_pend);
                        if (do_major) begin
                            r_due   <= 1'b1;
                            r_major <= r_major + WideW'(1);
                        end
                        r_dvd     <= step_sum;
                        r_rem     <= '0;
                        r_div_n   <= eff_n;
                        r_div_cnt <= DivCntW'(SumW);
                        r_state   <= S_DIV;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_DIV: begin
                    // One remainder bit per cycle, most significant first.
                    r_rem     <= div_ge ? div_diff[CfgW-1:0] : div_trial[CfgW-1:0];
                    r_dvd     <= {r_dvd[SumW-2:0], 1'b0};
                    r_div_cnt <= r_div_cnt - DivCntW'(1);
                    if (r_div_cnt == DivCntW'(1)) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // The slot takes the remainder as the last step retires.
            if (r_state == S_DIV && r_div_cnt == DivCntW'(1)) begin
                r_slot <= div_ge ? div_diff[SlotW-1:0] : div_trial[SlotW-1:0];
            end
        end
    end

    // Output register: loaded with a snapshot, held while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && out_free) begin
            r_out_data <= {(OutW - OutBits)'(0), r_tick, r_body_worst, r_body_last,
                           r_ovr_worst, r_ovr_lost, r_ovr_events, r_major, r_elapsed,
                           r_slot, r_due, r_wait, r_done};
        end
    end

    // An accepted event closes the input until its status is produced.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !s_axis_tready)
        else $error("input ready while an event is in work");

    // A status never reports a completed wait and a held wait together.
    a_collect_excl_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("collected and waiting both set");

    // A wait is held only by a wait request in the update step.
    a_wait_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_wait) |-> $past(r_state == S_UPD && r_mode == MODE_WAIT))
        else $error("wait flag set outside a wait request");

    // While dividing, the remainder unit holds a value below the slot count.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div_n))
        else $error("remainder out of range");

endmodule
